@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with active-low reset disable.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/lsc_pkg.sv @@
// Shared constants, codes and controller/datapath types of the lottery scheduler.
`timescale 1ns / 1ps
package lsc_pkg;
    localparam int MAX_TASKS = 32;
    localparam int PID_BITS  = 10;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TKT_W     = 17;
    localparam int SUM_W     = 22;
    localparam int TICK_W    = 17;
    localparam int Q_W       = 16;
    localparam int RND_W     = 32;
    localparam int MODE_W    = 3;
    localparam int ST_W      = 2;
    localparam int FLG_W     = 2;
    localparam int OP_W      = 5;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNBLOCK = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLOCK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd4;

    localparam logic [FLG_W-1:0] FLAG_NORMAL  = 2'd0;
    localparam logic [FLG_W-1:0] FLAG_COMP    = 2'd1;
    localparam logic [FLG_W-1:0] FLAG_BLOCKED = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

    localparam logic [OP_W-1:0] DP_NOP        = 5'd0;
    localparam logic [OP_W-1:0] DP_LATCH      = 5'd1;
    localparam logic [OP_W-1:0] DP_LOAD       = 5'd2;
    localparam logic [OP_W-1:0] DP_FIND_CLR   = 5'd3;
    localparam logic [OP_W-1:0] DP_IDX_INC    = 5'd4;
    localparam logic [OP_W-1:0] DP_UNBLOCK    = 5'd5;
    localparam logic [OP_W-1:0] DP_TICK       = 5'd6;
    localparam logic [OP_W-1:0] DP_QDIV_START = 5'd7;
    localparam logic [OP_W-1:0] DP_COMP       = 5'd8;
    localparam logic [OP_W-1:0] DP_EXIT_SUB   = 5'd9;
    localparam logic [OP_W-1:0] DP_SHIFT      = 5'd10;
    localparam logic [OP_W-1:0] DP_DEC_TOTAL  = 5'd11;
    localparam logic [OP_W-1:0] DP_MOD_START  = 5'd12;
    localparam logic [OP_W-1:0] DP_DRAW_INIT  = 5'd13;
    localparam logic [OP_W-1:0] DP_WALK       = 5'd14;
    localparam logic [OP_W-1:0] DP_WIN        = 5'd15;
    localparam logic [OP_W-1:0] DP_GO_IDLE    = 5'd16;
    localparam logic [OP_W-1:0] DP_RESULT     = 5'd17;
    localparam logic [OP_W-1:0] DP_SET_ST     = 5'd18;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ST_W-1:0] st;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic full;
        logic run_idle;
        logic sum_zero;
        logic idx_end;
        logic key_hit;
        logic ent_blocked;
        logic draw_hit;
        logic q_eq_ticks;
        logic div_busy;
        logic out_busy;
    } t_sts;
endpackage

@@ hdl/lsc_div.sv @@
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
`timescale 1ns / 1ps
module lsc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lsc_pkg::RND_W-1:0] i_dividend,
    input  logic [lsc_pkg::SUM_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [lsc_pkg::RND_W-1:0] o_quo,
    output logic [lsc_pkg::SUM_W-1:0] o_rem
);
    localparam int CW = $clog2(lsc_pkg::RND_W + 1);

    logic [CW-1:0]               r_cnt;
    logic [lsc_pkg::RND_W-1:0]   r_quo;
    logic [lsc_pkg::SUM_W-1:0]   r_rem;
    logic [lsc_pkg::SUM_W-1:0]   r_dvs;
    logic [lsc_pkg::SUM_W:0]     w_sh;
    logic [lsc_pkg::SUM_W:0]     w_diff;
    logic                        w_ge;

    assign w_sh   = {r_rem, r_quo[lsc_pkg::RND_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(lsc_pkg::RND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[lsc_pkg::RND_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[lsc_pkg::SUM_W-1:0] : w_sh[lsc_pkg::SUM_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

@@ hdl/lsc_dp.sv @@
// Scheduler datapath: task table, ticket and tick registers, divider, result register.
`timescale 1ns / 1ps
module lsc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lsc_pkg::t_cmd                i_cmd,
    input  logic [lsc_pkg::Q_W-1:0]      i_quantum,
    input  logic [lsc_pkg::MODE_W-1:0]   i_mode,
    input  logic [lsc_pkg::PID_BITS-1:0] i_pid,
    input  logic [lsc_pkg::RND_W-1:0]    i_rnd,
    input  logic                         i_out_ready,
    output lsc_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    output logic [lsc_pkg::PID_BITS-1:0] o_next_pid,
    output logic                         o_is_idle,
    output logic [lsc_pkg::ST_W-1:0]     o_status
);
    localparam int IW = lsc_pkg::IDX_W;
    localparam int CW = lsc_pkg::CNT_W;
    localparam int PW = lsc_pkg::PID_BITS;
    localparam int TW = lsc_pkg::TKT_W;
    localparam int SW = lsc_pkg::SUM_W;

    logic [PW-1:0]            r_ids [lsc_pkg::MAX_TASKS];
    logic [TW-1:0]            r_tkt [lsc_pkg::MAX_TASKS];
    logic [lsc_pkg::FLG_W-1:0] r_flg [lsc_pkg::MAX_TASKS];

    logic [CW-1:0]            r_total;
    logic [SW-1:0]            r_sum;
    logic [lsc_pkg::TICK_W-1:0] r_ticks;
    logic [PW-1:0]            r_run_pid;
    logic                     r_run_idle;
    logic [CW-1:0]            r_idx;
    logic [SW-1:0]            r_acc;
    logic [SW-1:0]            r_target;
    logic [lsc_pkg::MODE_W-1:0] r_mode;
    logic [PW-1:0]            r_pid;
    logic [lsc_pkg::RND_W-1:0] r_rnd;
    logic [lsc_pkg::ST_W-1:0] r_status;
    logic                     r_out_valid;
    logic [PW-1:0]            r_out_pid;
    logic                     r_out_idle;
    logic [lsc_pkg::ST_W-1:0] r_out_st;

    logic [PW-1:0]             e_id;
    logic [TW-1:0]             e_tkt;
    logic [lsc_pkg::FLG_W-1:0] e_flg;
    logic [PW-1:0]             w_key;
    logic [SW-1:0]             w_acc_nxt;
    logic [TW:0]               w_comp;
    logic [TW-1:0]             w_comp_sat;
    logic                      w_we;
    logic [IW-1:0]             w_wa;
    logic [PW-1:0]             w_wid;
    logic [TW-1:0]             w_wtkt;
    logic [lsc_pkg::FLG_W-1:0] w_wflg;
    logic                      w_div_start;
    logic [lsc_pkg::RND_W-1:0] w_dividend;
    logic [SW-1:0]             w_divisor;
    logic                      w_div_busy;
    logic [lsc_pkg::RND_W-1:0] w_quo;
    logic [SW-1:0]             w_rem;
    logic [CW-1:0]             w_idx_m1;

    assign e_id  = r_ids[r_idx[IW-1:0]];
    assign e_tkt = r_tkt[r_idx[IW-1:0]];
    assign e_flg = r_flg[r_idx[IW-1:0]];
    assign w_key = (r_mode == lsc_pkg::MODE_UNBLOCK) ? r_pid : r_run_pid;
    assign w_acc_nxt = r_acc + SW'(e_tkt);
    assign w_comp = {1'b0, e_tkt} + (TW + 1)'(w_quo[lsc_pkg::Q_W-1:0]);
    assign w_comp_sat = w_comp[TW] ? {TW{1'b1}} : w_comp[TW-1:0];
    assign w_idx_m1 = r_idx - 1'b1;

    assign w_div_start = (i_cmd.op == lsc_pkg::DP_MOD_START) ||
                         (i_cmd.op == lsc_pkg::DP_QDIV_START);
    assign w_dividend  = (i_cmd.op == lsc_pkg::DP_MOD_START) ? r_rnd
                         : lsc_pkg::RND_W'(i_quantum);
    assign w_divisor   = (i_cmd.op == lsc_pkg::DP_MOD_START) ? r_sum : SW'(r_ticks);

    lsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // single table write port
    always_comb begin
        w_we   = 1'b0;
        w_wa   = r_idx[IW-1:0];
        w_wid  = e_id;
        w_wtkt = e_tkt;
        w_wflg = e_flg;
        unique case (i_cmd.op)
            lsc_pkg::DP_LOAD: begin
                w_we   = 1'b1;
                w_wa   = r_total[IW-1:0];
                w_wid  = r_pid;
                w_wtkt = TW'(1);
                w_wflg = lsc_pkg::FLAG_NORMAL;
            end
            lsc_pkg::DP_UNBLOCK: begin
                w_we   = e_flg == lsc_pkg::FLAG_BLOCKED;
                w_wflg = lsc_pkg::FLAG_COMP;
            end
            lsc_pkg::DP_COMP: begin
                w_we   = 1'b1;
                w_wtkt = w_comp_sat;
                w_wflg = lsc_pkg::FLAG_BLOCKED;
            end
            lsc_pkg::DP_SHIFT: begin
                w_we = 1'b1;
                w_wa = w_idx_m1[IW-1:0];
            end
            lsc_pkg::DP_WIN: begin
                w_we   = e_flg == lsc_pkg::FLAG_COMP;
                w_wtkt = TW'(1);
                w_wflg = lsc_pkg::FLAG_NORMAL;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ids[w_wa] <= w_wid;
            r_tkt[w_wa] <= w_wtkt;
            r_flg[w_wa] <= w_wflg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_sum      <= '0;
            r_ticks    <= '0;
            r_run_pid  <= '0;
            r_run_idle <= 1'b1;
            r_idx      <= '0;
            r_acc      <= '0;
            r_status   <= lsc_pkg::ST_OK;
        end else begin
            unique case (i_cmd.op)
                lsc_pkg::DP_LATCH:    r_status <= lsc_pkg::ST_OK;
                lsc_pkg::DP_SET_ST:   r_status <= i_cmd.st;
                lsc_pkg::DP_LOAD: begin
                    r_total <= r_total + 1'b1;
                    r_sum   <= r_sum + 1'b1;
                end
                lsc_pkg::DP_FIND_CLR: r_idx <= '0;
                lsc_pkg::DP_IDX_INC:  r_idx <= r_idx + 1'b1;
                lsc_pkg::DP_UNBLOCK: begin
                    if (e_flg == lsc_pkg::FLAG_BLOCKED) r_sum <= r_sum + SW'(e_tkt);
                end
                lsc_pkg::DP_TICK: begin
                    if (r_ticks != '1) r_ticks <= r_ticks + 1'b1;
                end
                lsc_pkg::DP_COMP:     r_sum <= r_sum - SW'(e_tkt);
                lsc_pkg::DP_EXIT_SUB: begin
                    if (e_flg != lsc_pkg::FLAG_BLOCKED) r_sum <= r_sum - SW'(e_tkt);
                    r_idx <= r_idx + 1'b1;
                end
                lsc_pkg::DP_SHIFT:    r_idx <= r_idx + 1'b1;
                lsc_pkg::DP_DEC_TOTAL: r_total <= r_total - 1'b1;
                lsc_pkg::DP_DRAW_INIT: begin
                    r_ticks <= '0;
                    r_idx   <= '0;
                    r_acc   <= '0;
                end
                lsc_pkg::DP_WALK: begin
                    if (e_flg != lsc_pkg::FLAG_BLOCKED) r_acc <= w_acc_nxt;
                    r_idx <= r_idx + 1'b1;
                end
                lsc_pkg::DP_WIN: begin
                    if (e_flg == lsc_pkg::FLAG_COMP) r_sum <= r_sum - SW'(e_tkt) + 1'b1;
                    r_run_pid  <= e_id;
                    r_run_idle <= 1'b0;
                end
                lsc_pkg::DP_GO_IDLE:  r_run_idle <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // captured event word and draw target
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lsc_pkg::DP_LATCH) begin
            r_mode <= i_mode;
            r_pid  <= i_pid;
            r_rnd  <= i_rnd;
        end
        if (i_cmd.op == lsc_pkg::DP_DRAW_INIT) begin
            r_target <= w_rem;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == lsc_pkg::DP_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lsc_pkg::DP_RESULT) begin
            r_out_pid  <= r_run_idle ? '0 : r_run_pid;
            r_out_idle <= r_run_idle;
            r_out_st   <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_next_pid  = r_out_pid;
    assign o_is_idle   = r_out_idle;
    assign o_status    = r_out_st;

    assign o_sts.mode        = r_mode;
    assign o_sts.full        = r_total >= CW'(lsc_pkg::MAX_TASKS);
    assign o_sts.run_idle    = r_run_idle;
    assign o_sts.sum_zero    = r_sum == '0;
    assign o_sts.idx_end     = r_idx >= r_total;
    assign o_sts.key_hit     = e_id == w_key;
    assign o_sts.ent_blocked = e_flg == lsc_pkg::FLAG_BLOCKED;
    assign o_sts.draw_hit    = w_acc_nxt > r_target;
    assign o_sts.q_eq_ticks  = lsc_pkg::TICK_W'(i_quantum) == r_ticks;
    assign o_sts.div_busy    = w_div_busy;
    assign o_sts.out_busy    = r_out_valid && !i_out_ready;
endmodule

@@ hdl/lsc_ctrl.sv @@
// Scheduler controller: sequences table searches, divisions, compaction and the draw.
`timescale 1ns / 1ps
module lsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lsc_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output lsc_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_FIND  = 4'd2;
    localparam logic [3:0] S_BLK   = 4'd3;
    localparam logic [3:0] S_QDIV  = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_TCHK  = 4'd6;
    localparam logic [3:0] S_DRAW  = 4'd7;
    localparam logic [3:0] S_MOD   = 4'd8;
    localparam logic [3:0] S_WALK  = 4'd9;
    localparam logic [3:0] S_RES   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = lsc_pkg::DP_NOP;
        o_cmd.st  = lsc_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = lsc_pkg::DP_LATCH;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_sts.mode)
                    lsc_pkg::MODE_LOAD: begin
                        if (i_sts.full) begin
                            o_cmd.op = lsc_pkg::DP_SET_ST;
                            o_cmd.st = lsc_pkg::ST_FULL;
                        end else begin
                            o_cmd.op = lsc_pkg::DP_LOAD;
                        end
                        n_state = S_RES;
                    end
                    lsc_pkg::MODE_UNBLOCK: begin
                        o_cmd.op = lsc_pkg::DP_FIND_CLR;
                        n_state  = S_FIND;
                    end
                    lsc_pkg::MODE_BLOCK, lsc_pkg::MODE_EXIT: begin
                        if (i_sts.run_idle) begin
                            o_cmd.op = lsc_pkg::DP_SET_ST;
                            o_cmd.st = lsc_pkg::ST_NOTFOUND;
                            n_state  = S_RES;
                        end else begin
                            o_cmd.op = lsc_pkg::DP_FIND_CLR;
                            n_state  = S_FIND;
                        end
                    end
                    lsc_pkg::MODE_TICK: begin
                        o_cmd.op = lsc_pkg::DP_TICK;
                        n_state  = S_TCHK;
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end
            S_FIND: begin
                priority if (i_sts.idx_end) begin
                    o_cmd.op = lsc_pkg::DP_SET_ST;
                    o_cmd.st = lsc_pkg::ST_NOTFOUND;
                    n_state  = S_RES;
                end else if (i_sts.key_hit) begin
                    priority if (i_sts.mode == lsc_pkg::MODE_UNBLOCK) begin
                        o_cmd.op = lsc_pkg::DP_UNBLOCK;
                        n_state  = S_RES;
                    end else if (i_sts.mode == lsc_pkg::MODE_BLOCK) begin
                        o_cmd.op = lsc_pkg::DP_TICK;
                        n_state  = S_BLK;
                    end else begin
                        o_cmd.op = lsc_pkg::DP_EXIT_SUB;
                        n_state  = S_SHIFT;
                    end
                end else begin
                    o_cmd.op = lsc_pkg::DP_IDX_INC;
                end
            end
            S_BLK: begin
                if (i_sts.ent_blocked) begin
                    n_state = S_DRAW;
                end else begin
                    o_cmd.op = lsc_pkg::DP_QDIV_START;
                    n_state  = S_QDIV;
                end
            end
            S_QDIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = lsc_pkg::DP_COMP;
                    n_state  = S_DRAW;
                end
            end
            S_SHIFT: begin
                if (i_sts.idx_end) begin
                    o_cmd.op = lsc_pkg::DP_DEC_TOTAL;
                    n_state  = S_DRAW;
                end else begin
                    o_cmd.op = lsc_pkg::DP_SHIFT;
                end
            end
            S_TCHK: begin
                priority if ((i_sts.q_eq_ticks || i_sts.run_idle) && !i_sts.sum_zero) begin
                    n_state = S_DRAW;
                end else if (i_sts.q_eq_ticks) begin
                    o_cmd.op = lsc_pkg::DP_GO_IDLE;
                    n_state  = S_RES;
                end else begin
                    n_state = S_RES;
                end
            end
            S_DRAW: begin
                if (i_sts.sum_zero) begin
                    o_cmd.op = lsc_pkg::DP_GO_IDLE;
                    n_state  = S_RES;
                end else begin
                    o_cmd.op = lsc_pkg::DP_MOD_START;
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = lsc_pkg::DP_DRAW_INIT;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                priority if (i_sts.idx_end) begin
                    o_cmd.op = lsc_pkg::DP_GO_IDLE;
                    n_state  = S_RES;
                end else if (!i_sts.ent_blocked && i_sts.draw_hit) begin
                    o_cmd.op = lsc_pkg::DP_WIN;
                    n_state  = S_RES;
                end else begin
                    o_cmd.op = lsc_pkg::DP_WALK;
                end
            end
            S_RES: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = lsc_pkg::DP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

@@ hdl/lottery_scheduler_compensation_top.sv @@
// Top level of the lottery scheduler with compensation tickets.
`timescale 1ns / 1ps
// Lottery scheduler over an ordered task table of lsc_pkg::MAX_TASKS entries. Each input
// word is one event (load, unblock, block, tick, exit, kind in s_axis_tuser) and gives
// exactly one output word with the task to run next, an idle flag and a status. Events
// are handled one at a time; a finished result sits in the output register, so the next
// event is taken while it waits. Unblock is a linear pid search, one entry per cycle. A
// draw runs the 32-bit modulo in the shared one-bit-per-cycle divider and then walks the
// table. Block adds the search and, unless the entry is already blocked, a second
// division for the compensation; exit adds the search and compacts the table by shifting
// the later entries down. The quantum register is at byte address 0 of the APB port.
module lottery_scheduler_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [9:0] pid, [41:10] random_word, rest zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] next_pid, rest zero
    output logic [2:0]  m_axis_tuser,   // [0] is_idle, [2:1] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [lsc_pkg::Q_W-1:0]      r_quantum;
    lsc_pkg::t_cmd                w_cmd;
    lsc_pkg::t_sts                w_sts;
    logic [lsc_pkg::PID_BITS-1:0] w_next_pid;
    logic                         w_is_idle;
    logic [lsc_pkg::ST_W-1:0]     w_status;

    // config: one register, quantum at index 0
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= lsc_pkg::Q_W'(10);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_quantum <= pwdata[lsc_pkg::Q_W-1:0];
        end
    end
    assign prdata = paddr[2] ? 32'd0 : 32'(r_quantum);

    lsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    lsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_quantum   (r_quantum),
        .i_mode      (s_axis_tuser),
        .i_pid       (s_axis_tdata[9:0]),
        .i_rnd       (s_axis_tdata[41:10]),
        .i_out_ready (m_axis_tready),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_next_pid  (w_next_pid),
        .o_is_idle   (w_is_idle),
        .o_status    (w_status)
    );

    assign m_axis_tdata = 16'(w_next_pid);
    assign m_axis_tuser = {w_status, w_is_idle};
endmodule

@@ hdl/lsc_checker.sv @@
// Port-level checker for the lottery scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        pready
);
    `ASSERT_CLK(a_idle_pid_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0, "idle result with nonzero pid")
    `ASSERT_CLK(a_status_legal, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3, "illegal status code")
    `ASSERT_ALWAYS(a_pready_high, i_clk, pready, "pready dropped")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
endmodule

bind lottery_scheduler_compensation_top lsc_checker u_lsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pready        (pready)
);
